### src/rht_pkg.sv
// ----------------------------------------------------------------------------
// rht_pkg: shared types and codes for the reference-counted handle table
// Holds the sequencer states, command kinds, result status codes and the
// layout of one slot entry as kept in the slot memory.
// ----------------------------------------------------------------------------
package rht_pkg;

    // Field widths fixed by the stream layout
    localparam int OBJ_W   = 16;
    localparam int CNT_W   = 16;
    localparam int SLOT_W  = 6;
    localparam int OFF_W   = 6;
    localparam int BLK_W   = 16;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Command kinds on the input tuser
    localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Result status codes on the output tuser
    localparam logic [STAT_W-1:0] STAT_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FETCH    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_PUT_KEPT = 3'd3;
    localparam logic [STAT_W-1:0] STAT_PUT_WB   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_PUT_IDLE = 3'd5;
    localparam logic [STAT_W-1:0] STAT_CLEARED  = 3'd6;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_PUT,
        ST_CLR,
        ST_DIV_MUL,
        ST_DIV_REM,
        ST_DIV_FIX,
        ST_EMIT
    } t_state;

    // One slot as stored in memory
    typedef struct packed {
        logic [OBJ_W-1:0] obj;
        logic [CNT_W-1:0] cnt;
    } t_entry;

endpackage

### src/rht_ram.sv
// ----------------------------------------------------------------------------
// rht_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module rht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/refcounted_handle_table_top.sv
// ----------------------------------------------------------------------------
// refcounted_handle_table_top: reference-counted table of open-object slots
// Gets look up or claim a slot by object number, puts release a slot, clear
// empties the table. Slot state lives in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis channel (tuser = kind, tdata = object number
//   and slot index); one result per get, put or clear leaves on m_axis
//   (tuser = status, tdata = slot, object, block, offset, count). Kind 3 is
//   taken and dropped without a result.
//   One command is worked on at a time. A get reads the slot RAM one entry
//   per cycle, paced by the single RAM read port, and stops at the first
//   live match. A put that writes back also runs the block-number divide.
//   A clear sweeps the RAM one entry per cycle.
//   The result sits in an output register: the next command is taken while
//   it waits, and the block holds its next result until m_axis_tready.
//   After reset the RAM is cleared in one pass, during which s_axis_tready
//   stays low; the first_table_block register resets to 3 and
//   may be written through i_cfg_wr_en/i_cfg_wr_data while the block is idle.
// ----------------------------------------------------------------------------
module refcounted_handle_table_top
    import rht_pkg::*;
#(
    parameter int SLOTS             = 64,
    parameter int OBJECTS_PER_BLOCK = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: first_table_block
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // Command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] object_number, [21:16] slot_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [5:0] slot_out, [21:6] object_out,
                                        // [37:22] block_number, [43:38] obj_offset,
                                        // [59:44] count_after
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    localparam int AW        = $clog2(SLOTS);
    localparam int CW        = $clog2(SLOTS + 1);
    localparam int EW        = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int DIV_SHIFT = 24;
    localparam int DIV_MW    = DIV_SHIFT + 1;
    localparam int DIV_MULT  = (1 << DIV_SHIFT) / OBJECTS_PER_BLOCK;
    localparam int PROD_W    = OBJ_W + DIV_MW;
    localparam int REM_W     = 10;

    // Slot index to output slot field, and back
    function automatic logic [SLOT_W-1:0] to_slot(input logic [AW-1:0] a);
        logic [EW-1:0] e;
        e = EW'(a);
        return e[SLOT_W-1:0];
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [SLOT_W-1:0] s);
        logic [EW-1:0] e;
        e = EW'(s);
        return e[AW-1:0];
    endfunction

    // Registers
    t_state              r_state, n_state;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_chk_vld, n_chk_vld;
    logic [AW-1:0]       r_chk_idx, n_chk_idx;
    logic                r_free_found, n_free_found;
    logic [AW-1:0]       r_free_idx, n_free_idx;
    logic [OBJ_W-1:0]    r_obj, n_obj;
    logic [15:0]         r_base;
    logic [STAT_W-1:0]   r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic [OBJ_W-1:0]    r_res_obj, n_res_obj;
    logic [BLK_W-1:0]    r_res_blk, n_res_blk;
    logic [OFF_W-1:0]    r_res_off, n_res_off;
    logic [CNT_W-1:0]    r_res_cnt, n_res_cnt;
    logic [OBJ_W-1:0]    r_div_num, n_div_num;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [OBJ_W-1:0]    r_quo, n_quo;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic                r_out_vld, n_out_vld;
    logic [63:0]         r_out_data, n_out_data;
    logic [STAT_W-1:0]   r_out_status, n_out_status;

    // RAM ports
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    t_entry              ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [$bits(t_entry)-1:0] ram_rd_raw;
    t_entry              q_ent;

    // Shared decode
    logic                s_accept;
    logic [KIND_W-1:0]   in_kind;
    logic [OBJ_W-1:0]    in_obj;
    logic [SLOT_W-1:0]   in_idx;
    logic                in_idx_out;
    logic                scan_issue;
    logic                scan_hit;
    logic                scan_free;
    logic                scan_last;
    logic                scan_any_free;
    logic [CNT_W-1:0]    hit_cnt;
    logic [CNT_W-1:0]    put_cnt;
    logic                out_free;
    logic [OBJ_W-1:0]    quo_est;
    logic [DIV_MW-1:0]   quo_mul;
    logic [DIV_MW-1:0]   rem_full;
    logic                rem_big;
    logic [REM_W-1:0]    rem_fix;

    rht_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_raw)
    );

    assign q_ent = t_entry'(ram_rd_raw);

    // Input transfer and field split
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_kind       = s_axis_tuser;
    assign in_obj        = s_axis_tdata[15:0];
    assign in_idx        = s_axis_tdata[21:16];
    assign in_idx_out    = (32'(in_idx) >= SLOTS);

    // Scan compare on the entry read last cycle
    assign scan_issue    = (r_state == ST_SCAN) && (r_addr < CW'(SLOTS));
    assign scan_hit      = r_chk_vld && (q_ent.cnt != '0) && (q_ent.obj == r_obj);
    assign scan_free     = r_chk_vld && (q_ent.cnt == '0);
    assign scan_last     = r_chk_vld && (r_chk_idx == AW'(SLOTS - 1));
    assign scan_any_free = r_free_found || scan_free;
    assign hit_cnt       = (q_ent.cnt == COUNT_MAX) ? COUNT_MAX : q_ent.cnt + 1'b1;
    assign put_cnt       = q_ent.cnt - 1'b1;

    // Divide by a constant: reciprocal multiply, then one correction step
    assign quo_est  = r_prod[DIV_SHIFT+OBJ_W-1:DIV_SHIFT];
    assign quo_mul  = DIV_MW'(quo_est) * DIV_MW'(OBJECTS_PER_BLOCK);
    assign rem_full = DIV_MW'(r_div_num) - quo_mul;
    assign rem_big  = (r_rem >= REM_W'(OBJECTS_PER_BLOCK));
    assign rem_fix  = rem_big ? (r_rem - REM_W'(OBJECTS_PER_BLOCK)) : r_rem;

    assign out_free = !r_out_vld || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_addr == CW'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_kind)
                        KIND_GET:   n_state = ST_SCAN;
                        KIND_PUT:   n_state = in_idx_out ? ST_EMIT : ST_PUT;
                        KIND_CLEAR: n_state = ST_CLR;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_state = ST_DIV_MUL;
                end else if (scan_last) begin
                    n_state = scan_any_free ? ST_DIV_MUL : ST_EMIT;
                end
            end
            ST_PUT: begin
                if (q_ent.cnt == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = (put_cnt == '0) ? ST_DIV_MUL : ST_EMIT;
                end
            end
            ST_CLR: begin
                if (r_addr == CW'(SLOTS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV_MUL: n_state = ST_DIV_REM;
            ST_DIV_REM: n_state = ST_DIV_FIX;
            ST_DIV_FIX: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Datapath, RAM control and result staging
    always_comb begin
        n_addr       = r_addr;
        n_chk_vld    = scan_issue;
        n_chk_idx    = r_chk_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_obj        = r_obj;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_obj    = r_res_obj;
        n_res_blk    = r_res_blk;
        n_res_off    = r_res_off;
        n_res_cnt    = r_res_cnt;
        n_div_num    = r_div_num;
        n_prod       = r_prod;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_vld    = r_out_vld && !m_axis_tready;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_chk_idx;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_addr[AW-1:0];

        case (r_state)
            // Sweep zeros through the slot RAM
            ST_INIT, ST_CLR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_addr[AW-1:0];
                n_addr      = r_addr + 1'b1;
                if (r_state == ST_CLR && r_addr == CW'(SLOTS - 1)) begin
                    n_res_status = STAT_CLEARED;
                    n_res_slot   = '0;
                    n_res_obj    = '0;
                    n_res_blk    = '0;
                    n_res_off    = '0;
                    n_res_cnt    = '0;
                end
            end
            // Take a command
            ST_IDLE: begin
                n_addr       = '0;
                n_free_found = 1'b0;
                n_obj        = in_obj;
                n_chk_idx    = to_addr(in_idx);
                if (s_accept && in_kind == KIND_PUT) begin
                    n_res_slot = in_idx;
                    if (in_idx_out) begin
                        n_res_status = STAT_PUT_IDLE;
                        n_res_obj    = '0;
                        n_res_blk    = '0;
                        n_res_off    = '0;
                        n_res_cnt    = '0;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = to_addr(in_idx);
                    end
                end
            end
            // Read one slot a cycle, check the one read last cycle
            ST_SCAN: begin
                ram_rd_en = scan_issue;
                n_chk_idx = r_addr[AW-1:0];
                if (scan_issue) begin
                    n_addr = r_addr + 1'b1;
                end
                n_res_obj = r_obj;
                n_div_num = r_obj;
                if (scan_hit) begin
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = r_chk_idx;
                    ram_wr_data.obj = r_obj;
                    ram_wr_data.cnt = hit_cnt;
                    n_res_status    = STAT_HIT;
                    n_res_slot      = to_slot(r_chk_idx);
                    n_res_cnt       = hit_cnt;
                end else if (scan_last) begin
                    if (scan_any_free) begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = r_free_found ? r_free_idx : r_chk_idx;
                        ram_wr_data.obj = r_obj;
                        ram_wr_data.cnt = CNT_W'(1);
                        n_res_status    = STAT_FETCH;
                        n_res_slot      = to_slot(ram_wr_addr);
                        n_res_cnt       = CNT_W'(1);
                    end else begin
                        n_res_status = STAT_FULL;
                        n_res_slot   = '0;
                        n_res_blk    = '0;
                        n_res_off    = '0;
                        n_res_cnt    = '0;
                    end
                end else if (scan_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_chk_idx;
                end
            end
            // Release the slot read on the command transfer
            ST_PUT: begin
                n_res_obj = q_ent.obj;
                n_div_num = q_ent.obj;
                if (q_ent.cnt == '0) begin
                    n_res_status = STAT_PUT_IDLE;
                    n_res_blk    = '0;
                    n_res_off    = '0;
                    n_res_cnt    = '0;
                end else begin
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = r_chk_idx;
                    ram_wr_data.obj = q_ent.obj;
                    ram_wr_data.cnt = put_cnt;
                    n_res_cnt       = put_cnt;
                    if (put_cnt == '0) begin
                        n_res_status = STAT_PUT_WB;
                    end else begin
                        n_res_status = STAT_PUT_KEPT;
                        n_res_blk    = '0;
                        n_res_off    = '0;
                    end
                end
            end
            // Block number and offset of the object
            ST_DIV_MUL: begin
                n_prod = PROD_W'(r_div_num) * PROD_W'(DIV_MULT);
            end
            ST_DIV_REM: begin
                n_quo = quo_est;
                n_rem = rem_full[REM_W-1:0];
            end
            ST_DIV_FIX: begin
                n_res_blk = r_base + r_quo + BLK_W'(rem_big);
                n_res_off = rem_fix[OFF_W-1:0];
            end
            // Hand the result to the output register
            ST_EMIT: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = {4'b0, r_res_cnt, r_res_off, r_res_blk, r_res_obj,
                                    r_res_slot};
                end
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_addr       <= '0;
            r_chk_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_out_vld    <= 1'b0;
            r_base       <= 16'd3;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_chk_vld    <= n_chk_vld;
            r_free_found <= n_free_found;
            r_out_vld    <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_free_idx   <= n_free_idx;
        r_obj        <= n_obj;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_obj    <= n_res_obj;
        r_res_blk    <= n_res_blk;
        r_res_off    <= n_res_off;
        r_res_cnt    <= n_res_cnt;
        r_div_num    <= n_div_num;
        r_prod       <= n_prod;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

`ifndef NO_ASSERTIONS
    // No command is taken in the cycle after reset: the clearing pass runs first
    a_init_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("command taken before slot RAM was cleared");

    // A get transfer starts the slot scan
    a_get_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_GET)
        |=> (r_state == ST_SCAN))
        else $error("get did not start a scan");

    // A hit or fetch never reports a zero count
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == STAT_HIT || m_axis_tuser == STAT_FETCH))
        |-> (m_axis_tdata[59:44] != 16'd0))
        else $error("hit or fetch with zero count");

    // The recorded free slot always lies before the slot under check
    a_free_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_chk_vld && r_free_found) |-> (r_free_idx < r_chk_idx))
        else $error("free slot recorded out of order");
`endif

endmodule
